@@ hw/rtl/gsmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmp_pkg
// Shared types, codes and the ramp table of the gauge stepper motion profiler.
// ----------------------------------------------------------------------------
package gsmp_pkg;

  localparam int unsigned ROM_SIZE = 23;

  localparam int unsigned DEF_RAMP_ENTRIES    = 23;
  localparam int unsigned DEF_CRUISE_DISTANCE = 800;
  localparam int unsigned DEF_CRUISE_DELAY    = 300;

  localparam logic [15:0] MAX_STEPS_RST = 16'd960;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef struct packed {
    logic        op;
    logic [15:0] position;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic        step_pulse;
    logic        direction_level;
    logic [15:0] current_position;
    logic        moving;
  } out_item_t;

  localparam logic [15:0] RAMP_DIST [ROM_SIZE] = '{
    16'd30,  16'd65,  16'd100, 16'd135, 16'd170, 16'd205, 16'd240, 16'd275,
    16'd310, 16'd345, 16'd380, 16'd415, 16'd450, 16'd485, 16'd520, 16'd555,
    16'd590, 16'd625, 16'd660, 16'd695, 16'd730, 16'd765, 16'd800
  };

  localparam logic [15:0] RAMP_DELAY [ROM_SIZE] = '{
    16'd3000, 16'd2920, 16'd2780, 16'd2600, 16'd2380, 16'd2140, 16'd1890,
    16'd1650, 16'd1420, 16'd1210, 16'd1020, 16'd860,  16'd730,  16'd620,
    16'd530,  16'd460,  16'd410,  16'd370,  16'd340,  16'd320,  16'd310,
    16'd305,  16'd300
  };

  // Delay for the first table entry whose distance exceeds span.
  function automatic logic [15:0] ramp_lookup(logic [15:0] span, int unsigned entries,
                                              logic [15:0] cruise_dist,
                                              logic [15:0] cruise_dly);
    logic [15:0] dly;
    logic        hit;
    dly = cruise_dly;
    hit = 1'b0;
    if (span < cruise_dist) begin
      for (int unsigned x = 0; x < ROM_SIZE; x++) begin
        if (!hit && (x < entries) && (RAMP_DIST[x] > span)) begin
          dly = RAMP_DELAY[x];
          hit = 1'b1;
        end
      end
    end
    return dly;
  endfunction

endpackage

@@ hw/rtl/gsmp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmp_core
// Motion state and the per-item update: target scheduling, move start and
// retarget, ramp delay lookup and step timing.
// ----------------------------------------------------------------------------
module gsmp_core
  import gsmp_pkg::*;
#(
  parameter int unsigned RAMP_ENTRIES    = DEF_RAMP_ENTRIES,
  parameter int unsigned CRUISE_DISTANCE = DEF_CRUISE_DISTANCE,
  parameter int unsigned CRUISE_DELAY    = DEF_CRUISE_DELAY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_vld,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output out_item_t   res
);

  localparam logic [15:0] CruiseDist = 16'(CRUISE_DISTANCE);
  localparam logic [15:0] CruiseDly  = 16'(CRUISE_DELAY);

  logic [15:0] max_steps_r;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] ta_r, ta_nxt;
  logic [15:0] tp_r, tp_nxt;
  logic [15:0] sd_r, sd_nxt;
  logic [15:0] sl_r, sl_nxt;
  logic [31:0] lst_r, lst_nxt;
  logic        act_r, act_nxt;
  dir_t        md_r, md_nxt;
  dir_t        pin_r, pin_nxt;

  logic [15:0] lim;
  dir_t        nd;
  logic [15:0] span;
  logic [15:0] dly;
  logic [31:0] elapsed;
  logic        pulse;

  assign lim = max_steps_r - 16'd1;

  always_comb begin
    pos_nxt = pos_r;
    ta_nxt  = ta_r;
    tp_nxt  = tp_r;
    sd_nxt  = sd_r;
    sl_nxt  = sl_r;
    lst_nxt = lst_r;
    act_nxt = act_r;
    md_nxt  = md_r;
    pin_nxt = pin_r;
    pulse   = 1'b0;
    nd      = (tp_r > pos_r) ? DIR_FWD : ((tp_r < pos_r) ? DIR_BACK : DIR_NONE);
    span    = 16'd0;
    dly     = 16'd0;
    elapsed = 32'd0;
    if (item_vld) begin
      if (item.op == OP_MOVE) begin
        // duplicate check uses the raw request, before the clamp
        if (item.position != tp_r) begin
          tp_nxt = (item.position > lim) ? lim : item.position;
        end
      end else begin
        if (ta_r != tp_r) begin
          if (!act_r) begin
            ta_nxt = tp_r;
            if (nd != DIR_NONE) begin
              act_nxt = 1'b1;
              md_nxt  = nd;
              sd_nxt  = 16'd0;
              sl_nxt  = (nd == DIR_FWD) ? (tp_r - pos_r) : (pos_r - tp_r);
              lst_nxt = item.now_us;
            end
          end else if (nd == md_r) begin
            // same-direction retarget: extend without slowing
            ta_nxt = tp_r;
            sl_nxt = (md_r == DIR_FWD) ? (tp_r - pos_r) : (pos_r - tp_r);
          end
        end
        span    = (sd_nxt < sl_nxt) ? sd_nxt : sl_nxt;
        dly     = ramp_lookup(span, RAMP_ENTRIES, CruiseDist, CruiseDly);
        elapsed = item.now_us - lst_nxt;
        if (act_nxt && (elapsed >= {16'd0, dly})) begin
          pulse = 1'b1;
          // resync once more than one interval behind
          lst_nxt = (elapsed > {15'd0, dly, 1'b0}) ? item.now_us : (lst_nxt + {16'd0, dly});
          pin_nxt = md_nxt;
          sd_nxt  = sd_nxt + 16'd1;
          sl_nxt  = sl_nxt - 16'd1;
          pos_nxt = (md_nxt == DIR_FWD) ? (pos_r + 16'd1) : (pos_r - 16'd1);
          if (pos_nxt == ta_nxt) begin
            act_nxt = 1'b0;
          end
        end
      end
    end
    res.step_pulse       = pulse;
    res.direction_level  = (pin_nxt == DIR_BACK);
    res.current_position = pos_nxt;
    res.moving           = act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RST;
      pos_r       <= 16'd0;
      ta_r        <= 16'd0;
      tp_r        <= 16'd0;
      sd_r        <= 16'd0;
      sl_r        <= 16'd0;
      lst_r       <= 32'd0;
      act_r       <= 1'b0;
      md_r        <= DIR_NONE;
      pin_r       <= DIR_NONE;
    end else begin
      if (cfg_we) begin
        max_steps_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
      ta_r  <= ta_nxt;
      tp_r  <= tp_nxt;
      sd_r  <= sd_nxt;
      sl_r  <= sl_nxt;
      lst_r <= lst_nxt;
      act_r <= act_nxt;
      md_r  <= md_nxt;
      pin_r <= pin_nxt;
    end
  end

`ifndef SYNTH
  // a step always moves the position by exactly one
  a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && res.step_pulse) |=>
      ((pos_r == $past(pos_r) + 16'd1) || (pos_r == $past(pos_r) - 16'd1)))
    else $error("step did not move position by one");

  // position only changes on a step
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(item_vld && res.step_pulse) |=> $stable(pos_r))
    else $error("position changed without a step");

  // a running move always has a direction
  a_dir_set: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (md_r != DIR_NONE))
    else $error("move active without direction");
`endif

endmodule

@@ hw/rtl/gsmp_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmp_outbuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module gsmp_outbuf
  import gsmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t   ent0_r, ent0_nxt;
  out_item_t   ent1_r, ent1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  cnt_pop;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_pop  = cnt_r;
    if (pop) begin
      ent0_nxt = ent1_r;
      cnt_pop  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_pop;
    if (push && (cnt_pop != 2'd2)) begin
      if (cnt_pop == 2'd0) begin
        ent0_nxt = push_data;
      end else begin
        ent1_nxt = push_data;
      end
      cnt_nxt = cnt_pop + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  // upstream never pushes into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full result buffer");

  // skid entry moves to the head on a transfer out
  a_skid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (full && pop) |=> (ent0_r == $past(ent1_r)))
    else $error("skid entry lost on transfer");
`endif

endmodule

@@ hw/rtl/gauge_stepper_motion_profiler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_stepper_motion_profiler
// Gauge stepper controller with trapezoidal ramp; one result per item.
// ----------------------------------------------------------------------------
// Every input item (poll or new target) yields exactly one result. An item is
// held in an input register and resolved from there into a two-entry result
// buffer, so a new item is taken every cycle while the result side keeps up.
// Throughput is set by the result buffer: with both entries waiting, input
// stalls. The max_steps register is written through the cfg port, which is
// always ready, and must only be written while no item is in flight.
// ----------------------------------------------------------------------------
module gauge_stepper_motion_profiler
  import gsmp_pkg::*;
#(
  parameter int unsigned RAMP_ENTRIES    = DEF_RAMP_ENTRIES,
  parameter int unsigned CRUISE_DISTANCE = DEF_CRUISE_DISTANCE,
  parameter int unsigned CRUISE_DELAY    = DEF_CRUISE_DELAY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic      in_vld_r;
  in_item_t  in_data_r;
  logic      buf_full;
  logic      proc_go;
  out_item_t res;

  assign proc_go   = in_vld_r && !buf_full;
  assign in_stall  = in_vld_r && buf_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  gsmp_core #(
    .RAMP_ENTRIES    (RAMP_ENTRIES),
    .CRUISE_DISTANCE (CRUISE_DISTANCE),
    .CRUISE_DELAY    (CRUISE_DELAY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (proc_go),
    .item      (in_data_r),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .res       (res)
  );

  gsmp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (proc_go),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gauge stepper motion profiler.
// ----------------------------------------------------------------------------
// A queue of target requests and time polls feeds a falling-edge driver. A
// rising-edge monitor runs its own motion model on every accepted item and
// checks each result transfer field by field. The run covers a directed
// opening, random move episodes under several max_steps settings, one long
// receiver hold-off, and a final long move up the acceleration ramp.
// ----------------------------------------------------------------------------
module tb_top;
  import gsmp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  gauge_stepper_motion_profiler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // motion model state
  logic [15:0] gauge_max = MAX_STEPS_RST;
  logic [15:0] pos_now = '0;
  logic [15:0] tgt_act = '0;
  logic [15:0] tgt_pend = '0;
  logic [15:0] n_done = '0;
  logic [15:0] n_left = '0;
  logic [31:0] t_last = '0;
  logic        running = 1'b0;
  dir_t        mdir = DIR_NONE;
  dir_t        pin = DIR_NONE;

  out_item_t   motion_exp[$];
  in_item_t    pend_items[$];
  out_item_t   got;
  out_item_t   want;

  int          err_count = 0;
  int          n_sent = 0;
  int          n_results = 0;
  int          n_polls = 0;
  int          n_requests = 0;
  int          n_pulses = 0;
  int          n_cfg = 0;
  int          fastest_us = 0;
  int          quiet_cycles = 0;

  logic        in_took = 1'b0;
  logic        cfg_took = 1'b0;
  logic        idle_on = 1'b1;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;

  // stimulus bookkeeping
  logic [31:0] clock_us = '0;
  logic [15:0] cur_max = MAX_STEPS_RST;
  logic [15:0] aim = '0;

  function automatic logic [31:0] ramp_delay_for(logic [15:0] span);
    if (span >= DEF_CRUISE_DISTANCE) return DEF_CRUISE_DELAY;
    for (int k = 0; k < ROM_SIZE; k++) begin
      if (RAMP_DIST[k] > span) return 32'(RAMP_DELAY[k]);
    end
    return DEF_CRUISE_DELAY;
  endfunction

  function automatic out_item_t profile_item(in_item_t it);
    out_item_t   r;
    logic [15:0] lim;
    logic [31:0] dly;
    logic [31:0] lag;
    dir_t        nd;
    r = '0;
    if (it.op == OP_MOVE) begin
      n_requests++;
      // duplicate check uses the raw position, before the clamp
      if (it.position != tgt_pend) begin
        lim = gauge_max - 16'd1;
        tgt_pend = (it.position > lim) ? lim : it.position;
      end
    end else begin
      n_polls++;
      if (tgt_act != tgt_pend) begin
        nd = (tgt_pend > pos_now) ? DIR_FWD : ((tgt_pend < pos_now) ? DIR_BACK : DIR_NONE);
        if (!running) begin
          tgt_act = tgt_pend;
          if (nd != DIR_NONE) begin
            running = 1'b1;
            mdir = nd;
            n_done = '0;
            n_left = (nd == DIR_FWD) ? tgt_act - pos_now : pos_now - tgt_act;
            t_last = it.now_us;
          end
        end else if (nd == mdir) begin
          // same direction: extend without slowing; reversals wait for the end
          tgt_act = tgt_pend;
          n_left = (mdir == DIR_FWD) ? tgt_act - pos_now : pos_now - tgt_act;
        end
      end
      if (running) begin
        dly = ramp_delay_for((n_done < n_left) ? n_done : n_left);
        lag = it.now_us - t_last;
        if (lag >= dly) begin
          t_last = t_last + dly;
          lag = it.now_us - t_last;
          if (lag > dly) t_last = it.now_us;
          pin = mdir;
          n_done = n_done + 16'd1;
          n_left = n_left - 16'd1;
          pos_now = (mdir == DIR_FWD) ? pos_now + 16'd1 : pos_now - 16'd1;
          if (pos_now == tgt_act) running = 1'b0;
          r.step_pulse = 1'b1;
          n_pulses++;
          if (fastest_us == 0 || int'(dly) < fastest_us) fastest_us = int'(dly);
        end
      end
    end
    r.direction_level = (pin == DIR_BACK);
    r.current_position = pos_now;
    r.moving = running;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint g, longint w);
    if (err_count < 30)
      $display("MISMATCH result %0d %s: got %0h, expected %0h", n_results, what, g, w);
    err_count++;
  endtask

  // driver: next item goes out once the previous one has transferred
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pend_items.size() != 0) begin
        in_data <= pend_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall: random bursts plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = 199;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      out_gap = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor, model and watchdog
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    cfg_took <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (motion_exp.size() == 0) begin
          flag_mismatch("with nothing expected", got, 0);
        end else begin
          want = motion_exp.pop_front();
          if (got.step_pulse !== want.step_pulse)
            flag_mismatch("step_pulse", got.step_pulse, want.step_pulse);
          if (got.direction_level !== want.direction_level)
            flag_mismatch("direction_level", got.direction_level, want.direction_level);
          if (got.current_position !== want.current_position)
            flag_mismatch("current_position", got.current_position, want.current_position);
          if (got.moving !== want.moving)
            flag_mismatch("moving", got.moving, want.moving);
        end
        n_results <= n_results + 1;
      end
      if (in_valid && !in_stall) motion_exp.push_back(profile_item(in_data));
      if (cfg_valid && cfg_ready) begin
        gauge_max = cfg_data;
        n_cfg++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_move(logic [15:0] p);
    in_item_t it;
    it.op = OP_MOVE;
    it.position = p;
    it.now_us = $urandom();
    pend_items.push_back(it);
    n_sent++;
  endtask

  task automatic push_poll(logic [31:0] dt);
    in_item_t it;
    clock_us = clock_us + dt;
    it.op = OP_POLL;
    it.position = 16'($urandom_range(0, 16'hFFFF));
    it.now_us = clock_us;
    pend_items.push_back(it);
    n_sent++;
  endtask

  function automatic logic [15:0] clamp_to_max(logic [15:0] p);
    logic [15:0] lim;
    lim = cur_max - 16'd1;
    return (p > lim) ? lim : p;
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1, 2:    return $urandom_range(0, 400);
      3:       return $urandom_range(3001, 9000);  // falls behind, can force a resync
      4:       return $urandom();                  // wild jump, may wrap the time
      default: return $urandom_range(250, 3100);
    endcase
  endfunction

  // move episodes: a target request (sometimes noisy or repeated), then polls
  task automatic random_episodes(int count);
    int          stop_at;
    int          t;
    int          top;
    logic [15:0] raw;
    logic [15:0] sane;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      top = (cur_max - 16'd1 < 16'd80) ? int'(cur_max - 16'd1) : 80;
      t = int'(aim) + $urandom_range(0, 60) - 30;
      if (t < 0) t = 0;
      if (t > top) t = top;
      sane = t[15:0];
      case ($urandom_range(0, 9))
        0: begin
          // full-range request, overwritten before any poll sees it
          raw = 16'($urandom_range(0, 16'hFFFF));
          if (sane == raw) sane = sane ^ 16'd1;
          push_move(raw);
          push_move(sane);
        end
        1: begin
          push_move(sane);
          push_move(sane);
        end
        2: begin
          if (cur_max - 16'd1 <= 16'd100) sane = 16'hFFFF;
          push_move(sane);
        end
        default: push_move(sane);
      endcase
      aim = clamp_to_max(sane);
      repeat ($urandom_range(1, 40)) push_poll(pick_dt());
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (n_results != n_sent);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max(logic [15:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
    cur_max = v;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening at the reset max_steps
    push_poll(32'd0);              // idle poll
    push_move(16'd0);              // duplicate of the reset target
    push_move(16'hFFFF);           // clamped, then replaced
    push_move(16'd3);
    push_poll(32'd100);            // starts the move
    push_poll(32'd2999);           // one microsecond short of the first step
    push_poll(32'd1);              // exactly on time
    push_move(16'd1);              // stop request while moving
    push_poll(32'd3000);
    push_move(16'd6);              // same-direction extension
    push_poll(32'd13900);          // far behind: resync
    clock_us = 32'hFFFF_FF00;
    push_poll(32'd0);
    push_poll(32'h0000_0300);      // time wraps through zero
    push_poll(32'h0000_0E00);
    push_move(16'd2);              // reversal waits for the move to end
    repeat (8) push_poll(32'd3000);
    clock_us = 32'hFFFF_FFFF;
    push_poll(32'd0);
    aim = 16'd2;

    random_episodes(50);
    write_max(16'd1);
    random_episodes(40);
    write_max(16'd100);
    random_episodes(50);
    @(posedge clk);
    long_hold_req = 1'b1;
    write_max(16'hFFFF);
    random_episodes(50);
    write_max(MAX_STEPS_RST);
    random_episodes(40);
    write_max(16'd0);
    random_episodes(50);

    // last part: no idling, one long move up the acceleration ramp
    wait_drain();
    @(posedge clk);
    idle_on = 1'b0;
    @(negedge clk);
    push_move(16'd400);
    repeat (420) push_poll(32'd3000);

    wait_drain();
    repeat (8) @(negedge clk);
    if (motion_exp.size() != 0) flag_mismatch("results never produced", motion_exp.size(), 0);
    $display("Covered %0d items: %0d polls, %0d target requests, %0d step pulses.",
             n_sent, n_polls, n_requests, n_pulses);
    $display("max_steps writes: %0d; shortest step interval seen: %0d us; mismatches: %0d",
             n_cfg, fastest_us, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gsmp_pkg.sv
hw/rtl/gsmp_core.sv
hw/rtl/gsmp_outbuf.sv
hw/rtl/gauge_stepper_motion_profiler.sv
dv/tb_top.sv
